// ===== sv/mmc3bm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3bm_pkg
// Shared types and constants for the MMC3-style bank mapper core.
// ----------------------------------------------------------------------------
package mmc3bm_pkg;

  // Kind of request carried in the action field.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_PRG   = 2'd1,
    ACT_CHR   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam logic CFG_HAS_WRAM    = 1'b0;
  localparam logic CFG_FOUR_SCREEN = 1'b1;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  // Field widths.
  localparam int ACTION_W  = 2;
  localparam int ADDRESS_W = 16;
  localparam int DATA_W    = 8;
  localparam int BANK_W    = 8;
  localparam int PRG_W     = 6;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // CPU write decode: address bits 15..13.
  localparam logic [2:0] REGION_BANK = 3'b100;  // 0x8000-0x9FFF
  localparam logic [2:0] REGION_MIRR = 3'b101;  // 0xA000-0xBFFF

  // Fixed PRG banks: FIXED_LOW fills slot 2 or 0, FIXED_HIGH fills slot 3.
  localparam logic [PRG_W-1:0] FIXED_LOW  = 6'h3E;
  localparam logic [PRG_W-1:0] FIXED_HIGH = 6'h3F;

  localparam logic [DATA_W-1:0] CHR_EVEN_MASK = 8'hFE;
  localparam logic [DATA_W-1:0] CHR_ODD_SET   = 8'h01;

endpackage

// ===== sv/mmc3_style_bank_mapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3_style_bank_mapper_core
// MMC3-style PRG/CHR bank switching with mirroring and work RAM control.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Content
//  --------  ---------  ------------------------------------------------------
//  s_*       in         request: action, address, write data
//  m_*       out        result: bank, mirroring, work RAM read/write rights
//  cfg_*     in         register write: has_wram (0), four_screen (1)
//
// One request is taken per clock while the result port is not stalled.
// Decode, register update and bank lookup are a single level of logic in
// front of the result register, so a result appears on the cycle after its
// request is accepted. The single result register is the only buffer:
// s_tready is high whenever that register is empty or is being emptied in
// the same cycle. Reset (synchronous, active high) restores all mapper
// registers to their power-on values and empties the result register.
//
module mmc3_style_bank_mapper_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // [1:0] action, [17:2] address, [25:18] data, [31:26] zero
  input  logic [mmc3bm_pkg::IN_TDATA_W-1:0]        s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // [7:0] bank, [8] mirror_horizontal, [9] wram_readable,
  // [10] wram_writable, [15:11] zero
  output logic [mmc3bm_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  logic                                     cfg_write,
  input  logic [mmc3bm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [mmc3bm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int BW = mmc3bm_pkg::BANK_W;
  localparam int PW = mmc3bm_pkg::PRG_W;
  localparam int DW = mmc3bm_pkg::DATA_W;

  // Unpacked request fields.
  mmc3bm_pkg::action_t                 action;
  logic [mmc3bm_pkg::ADDRESS_W-1:0]    address;
  logic [DW-1:0]                       data;

  assign action  = mmc3bm_pkg::action_t'(s_tdata[1:0]);
  assign address = s_tdata[17:2];
  assign data    = s_tdata[25:18];

  // Mapper state.
  logic          has_wram;
  logic          four_screen;
  logic [7:0]    bank_select;
  logic [7:0]    wram_control;
  logic [PW-1:0] prg_banks [2];
  logic [BW-1:0] chr_banks [8];
  logic          mirroring;

  logic [7:0]    bank_select_next;
  logic [7:0]    wram_control_next;
  logic [PW-1:0] prg_banks_next [2];
  logic [BW-1:0] chr_banks_next [8];
  logic          mirroring_next;

  // Result register.
  logic [BW-1:0] bank;
  logic          mirror_horizontal;
  logic          wram_readable;
  logic          wram_writable;
  logic [BW-1:0] bank_next;

  logic          accept;
  logic [2:0]    target;
  logic [1:0]    prg_slot;
  logic [2:0]    chr_slot;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign target   = bank_select[2:0];

  // Register update for a CPU write. Lookups leave the state alone.
  always_comb begin
    bank_select_next  = bank_select;
    wram_control_next = wram_control;
    prg_banks_next    = prg_banks;
    chr_banks_next    = chr_banks;
    mirroring_next    = mirroring;
    if (action == mmc3bm_pkg::ACT_WRITE) begin
      if (address[15:13] == mmc3bm_pkg::REGION_BANK) begin
        if (address[0]) begin
          // Odd address: load the bank register chosen by the target index.
          unique case (target)
            3'd0, 3'd1: begin
              // 2K CHR pair: even half and odd half of the written bank.
              chr_banks_next[{1'b0, target[0], 1'b0}] = data & mmc3bm_pkg::CHR_EVEN_MASK;
              chr_banks_next[{1'b0, target[0], 1'b1}] = data | mmc3bm_pkg::CHR_ODD_SET;
            end
            3'd2, 3'd3, 3'd4, 3'd5: begin
              chr_banks_next[target + 3'd2] = data;
            end
            default: begin
              prg_banks_next[target[0]] = data[PW-1:0];
            end
          endcase
        end else begin
          bank_select_next = data;
        end
      end else if (address[15:13] == mmc3bm_pkg::REGION_MIRR) begin
        if (address[0]) begin
          wram_control_next = data;
        end else if (!four_screen) begin
          mirroring_next = data[0];
        end
      end
    end
  end

  // Bank lookup against the current registers.
  assign prg_slot = address[14:13];
  assign chr_slot = address[12:10] ^ {bank_select[7], 2'b00};

  always_comb begin
    bank_next = '0;
    unique case (action)
      mmc3bm_pkg::ACT_PRG: begin
        unique case (prg_slot)
          2'd0: bank_next = {2'b00, bank_select[6] ? mmc3bm_pkg::FIXED_LOW : prg_banks[0]};
          2'd1: bank_next = {2'b00, prg_banks[1]};
          2'd2: bank_next = {2'b00, bank_select[6] ? prg_banks[0] : mmc3bm_pkg::FIXED_LOW};
          default: bank_next = {2'b00, mmc3bm_pkg::FIXED_HIGH};
        endcase
      end
      mmc3bm_pkg::ACT_CHR: begin
        bank_next = chr_banks[chr_slot];
      end
      default: begin
        bank_next = '0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_wram    <= 1'b1;
      four_screen <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmc3bm_pkg::CFG_HAS_WRAM:    has_wram    <= cfg_data[0];
        mmc3bm_pkg::CFG_FOUR_SCREEN: four_screen <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Mapper registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select  <= '0;
      wram_control <= '0;
      prg_banks[0] <= PW'(0);
      prg_banks[1] <= PW'(1);
      for (int i = 0; i < 8; i++) begin
        chr_banks[i] <= BW'(i);
      end
      mirroring    <= 1'b0;
    end else if (accept) begin
      bank_select  <= bank_select_next;
      wram_control <= wram_control_next;
      prg_banks    <= prg_banks_next;
      chr_banks    <= chr_banks_next;
      mirroring    <= mirroring_next;
    end
  end

  // Result register; status fields report the state after the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bank              <= bank_next;
      mirror_horizontal <= mirroring_next;
      wram_readable     <= wram_control_next[7];
      wram_writable     <= wram_control_next[7] && !wram_control_next[6] && has_wram;
    end
  end

  assign m_tdata = {5'b00000, wram_writable, wram_readable, mirror_horizontal, bank};

endmodule

// ===== dv/mmc3_style_bank_mapper_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3_style_bank_mapper_core_test
// Self-checking bench for the MMC3-style bank mapper core. A shadow copy of
// the mapper registers predicts the bank, mirroring and work RAM rights for
// every accepted request. Each result is then checked against the oldest
// prediction, under random back-pressure on both stream ports.
// ----------------------------------------------------------------------------
module mmc3_style_bank_mapper_core_test;

  // One predicted result, laid out field by field.
  typedef struct packed {
    logic [mmc3bm_pkg::BANK_W-1:0] bank;
    logic                          mirror_h;
    logic                          wram_rd;
    logic                          wram_wr;
  } mapping_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [mmc3bm_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [mmc3bm_pkg::OUT_TDATA_W-1:0]  m_tdata;
  logic                                cfg_write = 1'b0;
  logic [mmc3bm_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [mmc3bm_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  // Shadow copy of the mapper registers and of the two configuration bits.
  logic [7:0]                   shadow_select;
  logic [7:0]                   shadow_wram_ctl;
  logic [mmc3bm_pkg::PRG_W-1:0] shadow_prg [2];
  logic [7:0]                   shadow_chr [8];
  logic                         shadow_mirror;
  logic                         wram_fitted;
  logic                         four_screen_on;

  mapping_t pending_mappings [$];

  int send_idle_pct = 12;
  int recv_idle_pct = 58;
  int sent_count    = 0;
  int mismatches    = 0;

  mmc3_style_bank_mapper_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Work out the result of one request and update the shadow registers the
  // way the cartridge would. Writes report bank zero; lookups leave the
  // registers alone. The status fields reflect the state after the request.
  function automatic mapping_t map_request(mmc3bm_pkg::action_t act, logic [15:0] addr,
                                           logic [7:0] data);
    mapping_t   res;
    logic [2:0] target;
    logic [2:0] slot;
    res    = '0;
    target = shadow_select[2:0];
    case (act)
      mmc3bm_pkg::ACT_WRITE: begin
        if (addr[15:13] == mmc3bm_pkg::REGION_BANK) begin
          if (!addr[0]) begin
            shadow_select = data;
          end else if (target < 3'd2) begin
            // The two 2K CHR registers load an even/odd pair of 1K banks.
            shadow_chr[{target[1:0], 1'b0}] = data & mmc3bm_pkg::CHR_EVEN_MASK;
            shadow_chr[{target[1:0], 1'b1}] = data | mmc3bm_pkg::CHR_ODD_SET;
          end else if (target < 3'd6) begin
            shadow_chr[target + 3'd2] = data;
          end else begin
            shadow_prg[target[0]] = data[mmc3bm_pkg::PRG_W-1:0];
          end
        end else if (addr[15:13] == mmc3bm_pkg::REGION_MIRR) begin
          if (addr[0]) begin
            shadow_wram_ctl = data;
          end else if (!four_screen_on) begin
            shadow_mirror = data[0];
          end
        end
        // Anything else, the IRQ range included, is simply dropped.
      end
      mmc3bm_pkg::ACT_PRG: begin
        // Only bits 14..13 pick the slot, so addresses below 0x8000 wrap.
        case (addr[14:13])
          2'd0:    res.bank = {2'b00, shadow_select[6] ? mmc3bm_pkg::FIXED_LOW
                                                       : shadow_prg[0]};
          2'd1:    res.bank = {2'b00, shadow_prg[1]};
          2'd2:    res.bank = {2'b00, shadow_select[6] ? shadow_prg[0]
                                                       : mmc3bm_pkg::FIXED_LOW};
          default: res.bank = {2'b00, mmc3bm_pkg::FIXED_HIGH};
        endcase
      end
      mmc3bm_pkg::ACT_CHR: begin
        // Bits 12..10 pick the slot; the upper half swaps under bit 7.
        slot     = addr[12:10] ^ {shadow_select[7], 2'b00};
        res.bank = shadow_chr[slot];
      end
      default: ;
    endcase
    res.mirror_h = shadow_mirror;
    res.wram_rd  = shadow_wram_ctl[7];
    res.wram_wr  = shadow_wram_ctl[7] && !shadow_wram_ctl[6] && wram_fitted;
    return res;
  endfunction

  // Offer one request, possibly after a random gap, and record its predicted
  // result once the core has accepted it. Valid is left high afterwards so
  // that back-to-back requests keep it high without a break.
  task automatic send_request(mmc3bm_pkg::action_t act, logic [15:0] addr,
                              logic [7:0] data);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, data, addr, act};
    do @(posedge clk); while (!s_tready);
    pending_mappings.push_back(map_request(act, addr, data));
    sent_count++;
  endtask

  // Stop sending and wait until every predicted result has come back. Every
  // request yields a result, so the queue empties once the core is drained,
  // and the registers are touched only after that.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_mappings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Configuration writes are only issued while the core is idle.
  task automatic write_register(logic [mmc3bm_pkg::CFG_INDEX_W-1:0] idx, logic value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == mmc3bm_pkg::CFG_HAS_WRAM) wram_fitted = value;
    else four_screen_on = value;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Power-on contents: the default PRG and CHR banks and a null request.
  task automatic test_reset_values();
    send_request(mmc3bm_pkg::ACT_PRG, 16'h8000, 8'h00);
    send_request(mmc3bm_pkg::ACT_PRG, 16'hFFFF, 8'hFF);
    send_request(mmc3bm_pkg::ACT_CHR, 16'h0000, 8'h00);
    send_request(mmc3bm_pkg::ACT_NONE, 16'hFFFF, 8'hFF);
  endtask

  // Bank select with both mode bits, CHR pair forcing and the PRG registers.
  task automatic test_bank_registers();
    send_request(mmc3bm_pkg::ACT_WRITE, 16'h8000, 8'hC1);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'h8001, 8'hFF);
    send_request(mmc3bm_pkg::ACT_CHR,   16'h0800, 8'h00);
    send_request(mmc3bm_pkg::ACT_CHR,   16'h1800, 8'h00);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'h9FFE, 8'h47);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'h9FFF, 8'hFF);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'h8000, 8'h46);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'h8001, 8'h00);
    send_request(mmc3bm_pkg::ACT_PRG,   16'h8000, 8'h00);
    send_request(mmc3bm_pkg::ACT_PRG,   16'hC000, 8'h00);
  endtask

  // Mirroring and work RAM rights, including the effect of both registers.
  task automatic test_mirroring_and_wram();
    send_request(mmc3bm_pkg::ACT_WRITE, 16'hA000, 8'hFF);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'hA001, 8'h80);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'hA001, 8'hC0);
    wait_for_results();
    write_register(mmc3bm_pkg::CFG_HAS_WRAM, 1'b0);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'hBFFF, 8'h80);
    wait_for_results();
    write_register(mmc3bm_pkg::CFG_FOUR_SCREEN, 1'b1);
    // With four-screen nametables the mirroring write must have no effect.
    send_request(mmc3bm_pkg::ACT_WRITE, 16'hBFFE, 8'h00);
    wait_for_results();
    write_register(mmc3bm_pkg::CFG_HAS_WRAM, 1'b1);
    write_register(mmc3bm_pkg::CFG_FOUR_SCREEN, 1'b0);
  endtask

  // Writes outside the register window, and lookups that wrap.
  task automatic test_ignored_and_wrapping();
    send_request(mmc3bm_pkg::ACT_WRITE, 16'hC000, 8'hFF);
    send_request(mmc3bm_pkg::ACT_WRITE, 16'h7FFF, 8'hFF);
    send_request(mmc3bm_pkg::ACT_PRG,   16'h0000, 8'h00);
    send_request(mmc3bm_pkg::ACT_CHR,   16'hFFFF, 8'h00);
  endtask

  // Mostly meaningful traffic: select/data pairs and lookups, with some
  // writes anywhere in the address map and some null requests as noise.
  task automatic random_requests(int count);
    int          stop_at;
    int          pick;
    logic [15:0] addr;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        send_request(mmc3bm_pkg::ACT_PRG, 16'($urandom), 8'($urandom));
      end else if (pick < 56) begin
        send_request(mmc3bm_pkg::ACT_CHR, 16'($urandom), 8'($urandom));
      end else if (pick < 76) begin
        addr = 16'h8000 | (16'($urandom) & 16'h1FFE);
        send_request(mmc3bm_pkg::ACT_WRITE, addr, 8'($urandom));
        addr = 16'h8001 | (16'($urandom) & 16'h1FFF);
        send_request(mmc3bm_pkg::ACT_WRITE, addr, 8'($urandom));
      end else if (pick < 88) begin
        addr = 16'hA000 | (16'($urandom) & 16'h1FFF);
        send_request(mmc3bm_pkg::ACT_WRITE, addr, 8'($urandom));
      end else if (pick < 95) begin
        send_request(mmc3bm_pkg::ACT_WRITE, 16'($urandom), 8'($urandom));
      end else begin
        send_request(mmc3bm_pkg::ACT_NONE, 16'($urandom), 8'($urandom));
      end
      // Now and then let the core run completely dry.
      if ($urandom_range(0, 149) == 0) wait_for_results();
    end
  endtask

  // Three phases of random traffic, each with its own back-pressure profile
  // and configuration.
  task automatic test_random_traffic();
    random_requests(460);
    wait_for_results();
    send_idle_pct = 58;
    recv_idle_pct = 12;
    write_register(mmc3bm_pkg::CFG_HAS_WRAM, 1'b0);
    write_register(mmc3bm_pkg::CFG_FOUR_SCREEN, 1'b1);
    random_requests(460);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(mmc3bm_pkg::CFG_HAS_WRAM, 1'b1);
    random_requests(460);
  endtask

  // Result port back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every result taken from the core with the oldest prediction.
  always @(posedge clk) begin : check_results
    mapping_t want;
    mapping_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[10]};
      if (pending_mappings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing expected: bank %h mirror %b rd %b wr %b",
                   $realtime, got.bank, got.mirror_h, got.wram_rd, got.wram_wr);
        end
      end else begin
        want = pending_mappings.pop_front();
        if (got.bank !== want.bank || got.mirror_h !== want.mirror_h ||
            got.wram_rd !== want.wram_rd || got.wram_wr !== want.wram_wr) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: bank/mirror/rd/wr expected %h/%b/%b/%b, got %h/%b/%b/%b",
                     $realtime, want.bank, want.mirror_h, want.wram_rd, want.wram_wr,
                     got.bank, got.mirror_h, got.wram_rd, got.wram_wr);
          end
        end
      end
    end
  end

  initial begin
    shadow_select   = '0;
    shadow_wram_ctl = '0;
    shadow_prg[0]   = '0;
    shadow_prg[1]   = 6'd1;
    for (int i = 0; i < 8; i++) shadow_chr[i] = 8'(i);
    shadow_mirror   = 1'b0;
    wram_fitted     = 1'b1;
    four_screen_on  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Write both registers to their power-on values once before traffic.
    write_register(mmc3bm_pkg::CFG_HAS_WRAM, 1'b1);
    write_register(mmc3bm_pkg::CFG_FOUR_SCREEN, 1'b0);
    test_reset_values();
    test_bank_registers();
    test_mirroring_and_wram();
    test_ignored_and_wrapping();
    test_random_traffic();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("mmc3_style_bank_mapper_core_test OK");
    end else begin
      $display("mmc3_style_bank_mapper_core_test NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run needs a small fraction of this.
  initial begin
    #2000000;
    $display("mmc3_style_bank_mapper_core_test NOT OK");
    $finish;
  end

endmodule
